FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh: shared concurrent assertion macros
// Clocked, reset-qualified property checks used by the shard splitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the shard splitter
// Field widths, CRC-32 constants, queue entry and status structs, CRC step.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int DATA_W      = 8;
    localparam int LEN_W       = 25;
    localparam int NUM_W       = 32;
    localparam int CRC_W       = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

    localparam logic [LEN_W-1:0] SIZE_DEFAULT = 25'd65536;
    localparam logic [LEN_W-1:0] SIZE_MAX     = 25'd16777216;

    // One classified byte on its way from front to back.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              object_end;
        logic              close;
        logic [LEN_W-1:0]  length;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic [LEN_W-1:0] bytes_in_shard;
    } fstat_t;

    typedef struct packed {
        logic [NUM_W-1:0] shard_counter;
    } bstat_t;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [DATA_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-DATA_W){1'b0}}, data};
        for (int i = 0; i < DATA_W; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: src/ssc_if.sv
// ----------------------------------------------------------------------------
// ssc_if: stream interfaces for the shard splitter
// Byte channel in, shard descriptor channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface ssc_byte_if;
    logic                      valid;
    logic                      ready;
    logic [ssc_pkg::DATA_W-1:0] data_byte;
    logic                      object_end;

    modport source (output valid, output data_byte, output object_end, input ready);
    modport sink   (input valid, input data_byte, input object_end, output ready);
endinterface

interface ssc_shard_if;
    logic                      valid;
    logic                      ready;
    logic [ssc_pkg::NUM_W-1:0] shard_number;
    logic [ssc_pkg::LEN_W-1:0] shard_length;
    logic [ssc_pkg::CRC_W-1:0] crc_value;
    logic                      final_shard;

    modport source (output valid, output shard_number, output shard_length,
                    output crc_value, output final_shard, input ready);
    modport sink   (input valid, input shard_number, input shard_length,
                    input crc_value, input final_shard, output ready);
endinterface

FILE: src/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front: byte intake and shard boundary classification
// Counts bytes in the current shard and tags each byte that closes a shard.
// ----------------------------------------------------------------------------
module ssc_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    ssc_byte_if.sink                  stream,
    input  logic [ssc_pkg::LEN_W-1:0] eff_size,
    input  ssc_pkg::qstat_t           qstat,
    output logic                      push_valid,
    output ssc_pkg::entry_t           push_entry,
    output ssc_pkg::fstat_t           fstat
);

    logic [ssc_pkg::LEN_W-1:0] bytes_reg;
    logic [ssc_pkg::LEN_W-1:0] bytes_next;
    logic [ssc_pkg::LEN_W-1:0] count;
    logic                      close;
    logic                      accept;

    assign stream.ready = !qstat.full;
    assign accept       = stream.valid && stream.ready;

    // bytes_reg stays below 2^24, so the increment cannot wrap
    assign count = bytes_reg + 1'b1;
    assign close = (count >= eff_size) || stream.object_end;

    always_comb
    begin
        bytes_next = bytes_reg;
        if (accept)
        begin
            bytes_next = close ? '0 : count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
        end
        else
        begin
            bytes_reg <= bytes_next;
        end
    end

    assign push_valid            = stream.valid;
    assign push_entry.data_byte  = stream.data_byte;
    assign push_entry.object_end = stream.object_end;
    assign push_entry.close      = close;
    assign push_entry.length     = count;

    assign fstat.bytes_in_shard = bytes_reg;

endmodule

FILE: src/ssc_queue.sv
// ----------------------------------------------------------------------------
// ssc_queue: small FIFO between front and back
// Register array with wrapping pointers and a fill level.
// ----------------------------------------------------------------------------
module ssc_queue
#(
    parameter int DEPTH = ssc_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  ssc_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ssc_pkg::entry_t pop_entry,
    output ssc_pkg::qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

    ssc_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (level_reg == LVL_FULL);
    assign qstat.empty = (level_reg == '0);
    assign pop_valid   = !qstat.empty;
    assign pop_entry   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && !qstat.full;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back: CRC accumulation and shard descriptor output
// Folds one byte per cycle into the running CRC; a closing byte waits for a
// free output register, then loads it with shard number, length and final CRC.
// ----------------------------------------------------------------------------
module ssc_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  ssc_pkg::entry_t pop_entry,
    ssc_shard_if.source     result,
    output ssc_pkg::bstat_t bstat
);

    logic [ssc_pkg::CRC_W-1:0] crc_reg;
    logic [ssc_pkg::CRC_W-1:0] crc_next;
    logic [ssc_pkg::NUM_W-1:0] counter_reg;
    logic [ssc_pkg::NUM_W-1:0] counter_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [ssc_pkg::NUM_W-1:0] number_reg;
    logic [ssc_pkg::LEN_W-1:0] length_reg;
    logic [ssc_pkg::CRC_W-1:0] crc_out_reg;
    logic                      final_reg;
    logic [ssc_pkg::CRC_W-1:0] crc_step;
    logic                      slot_free;
    logic                      take;
    logic                      emit;

    assign crc_step  = ssc_pkg::crc32_byte(crc_reg, pop_entry.data_byte);
    assign slot_free = !out_valid_reg || result.ready;
    // non-closing bytes never wait on the output side
    assign pop_ready = !pop_entry.close || slot_free;
    assign take      = pop_valid && pop_ready;
    assign emit      = take && pop_entry.close;

    always_comb
    begin
        crc_next       = crc_reg;
        counter_next   = counter_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            crc_next = crc_step;
        end
        if (emit)
        begin
            crc_next       = ssc_pkg::CRC_ONES;
            counter_next   = pop_entry.object_end ? '0 : counter_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= ssc_pkg::CRC_ONES;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            number_reg  <= counter_reg;
            length_reg  <= pop_entry.length;
            crc_out_reg <= crc_step ^ ssc_pkg::CRC_ONES;
            final_reg   <= pop_entry.object_end;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.shard_number = number_reg;
    assign result.shard_length = length_reg;
    assign result.crc_value    = crc_out_reg;
    assign result.final_shard  = final_reg;

    assign bstat.shard_counter = counter_reg;

endmodule

FILE: src/shard_splitter_crc32.sv
// ----------------------------------------------------------------------------
// Usage: bytes of an object enter on stream (valid/ready), object_end set on
// the object's last byte. Each completed shard leaves on result as one
// transfer: shard number, length, CRC-32 (reflected, 0xEDB88320, inverted)
// and a flag for the object's last shard. cfg_write/cfg_data set the shard
// size (0 selects 65536, values above 2^24 clamp to 2^24); write it only
// while the block is idle.
// Throughput: one byte per clock while the queue is not full, set by the
// single-byte CRC step in the back end. A closing byte is written into the
// queue; from the queue head it loads the output register once that is free.
// Reset: shard size 65536, byte count and shard number zero, queue empty.
// Receiver stall: the back keeps folding non-closing bytes into the CRC; a
// closing byte waits in the queue, and stream.ready drops once the queue is
// full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shard_splitter_crc32
#(
    parameter int QUEUE_DEPTH = ssc_pkg::QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    ssc_byte_if.sink                  stream,
    ssc_shard_if.source               result,
    input  logic                      cfg_write,
    input  logic [ssc_pkg::LEN_W-1:0] cfg_data
);

    logic [ssc_pkg::LEN_W-1:0] eff_size_reg;
    logic [ssc_pkg::LEN_W-1:0] eff_size_next;
    logic                      push_valid;
    ssc_pkg::entry_t           push_entry;
    logic                      pop_valid;
    logic                      pop_ready;
    ssc_pkg::entry_t           pop_entry;
    ssc_pkg::qstat_t           qstat;
    ssc_pkg::fstat_t           fstat;
    ssc_pkg::bstat_t           bstat;

    // store the effective size so the front compare sees a clean register
    always_comb
    begin
        eff_size_next = eff_size_reg;
        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                eff_size_next = ssc_pkg::SIZE_DEFAULT;
            end
            else if (cfg_data > ssc_pkg::SIZE_MAX)
            begin
                eff_size_next = ssc_pkg::SIZE_MAX;
            end
            else
            begin
                eff_size_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_size_reg <= ssc_pkg::SIZE_DEFAULT;
        end
        else
        begin
            eff_size_reg <= eff_size_next;
        end
    end

    ssc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .eff_size   (eff_size_reg),
        .qstat      (qstat),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .fstat      (fstat)
    );

    ssc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    ssc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .result    (result),
        .bstat     (bstat)
    );

    `ASSERT_ALWAYS(a_queue_level_sane, clk, rst_n,
        !(qstat.full && qstat.empty), "queue both full and empty")
    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n,
        fstat.bytes_in_shard < ssc_pkg::SIZE_MAX, "shard byte count overran")
    `ASSERT_IMPLY(a_counter_follows_out, clk, rst_n,
        result.valid && !result.final_shard,
        bstat.shard_counter == (result.shard_number + 32'd1), "shard counter out of step")
    `ASSERT_IMPLY(a_counter_clears_final, clk, rst_n,
        result.valid && result.final_shard,
        bstat.shard_counter == '0, "shard counter not cleared after final shard")

endmodule

FILE: tb/shard_splitter_crc32_tb.sv
// ----------------------------------------------------------------------------
// shard_splitter_crc32_tb: self-checking testbench for the shard splitter
// Streams objects byte by byte through the splitter and checks every shard
// descriptor against an in-bench shard/CRC-32 predictor. Covers several
// shard sizes (including 0, the 2^24 limit and values that saturate), size
// changes with a shard partly filled, and random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module shard_splitter_crc32_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int NUM_PHASES    = 14;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / NUM_PHASES;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [ssc_pkg::LEN_W-1:0] cfg_data;

    ssc_byte_if  stream_if();
    ssc_shard_if shard_if();

    shard_splitter_crc32 uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .result    (shard_if),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Predicts shard descriptors from accepted bytes and checks the output.
    class shard_scoreboard;
        typedef struct {
            logic [ssc_pkg::NUM_W-1:0] number;
            logic [ssc_pkg::LEN_W-1:0] length;
            logic [ssc_pkg::CRC_W-1:0] crc;
            logic                      last;
        } shard_desc_t;

        shard_desc_t               pending_shards[$];
        logic [ssc_pkg::LEN_W-1:0] size_reg;
        logic [ssc_pkg::CRC_W-1:0] crc_acc;
        logic [ssc_pkg::LEN_W-1:0] taken;
        logic [ssc_pkg::NUM_W-1:0] index;
        int                        errors;
        int                        bytes_seen;
        int                        shards_checked;

        function new();
            size_reg       = ssc_pkg::SIZE_DEFAULT;
            crc_acc        = ssc_pkg::CRC_ONES;
            taken          = '0;
            index          = '0;
            errors         = 0;
            bytes_seen     = 0;
            shards_checked = 0;
        endfunction

        function void set_size(logic [ssc_pkg::LEN_W-1:0] v);
            size_reg = v;
        endfunction

        function int unsigned size_limit();
            if (size_reg == '0)
                return ssc_pkg::SIZE_DEFAULT;
            if (size_reg > ssc_pkg::SIZE_MAX)
                return ssc_pkg::SIZE_MAX;
            return size_reg;
        endfunction

        // Bit-serial reflected CRC: feedback is the low CRC bit xor the data bit.
        function logic [ssc_pkg::CRC_W-1:0] crc_fold(logic [ssc_pkg::CRC_W-1:0] acc,
                                                     logic [ssc_pkg::DATA_W-1:0] b);
            logic [ssc_pkg::CRC_W-1:0] r;
            r = acc;
            for (int k = 0; k < ssc_pkg::DATA_W; k++)
            begin
                r = {1'b0, r[ssc_pkg::CRC_W-1:1]} ^ ((r[0] ^ b[k]) ? ssc_pkg::CRC_POLY : '0);
            end
            return r;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task note_byte(logic [ssc_pkg::DATA_W-1:0] b, logic last);
            int unsigned cnt;
            shard_desc_t d;
            bytes_seen++;
            crc_acc = crc_fold(crc_acc, b);
            cnt = taken + 1;
            if (cnt >= size_limit() || last)
            begin
                d.number = index;
                d.length = cnt[ssc_pkg::LEN_W-1:0];
                d.crc    = crc_acc ^ ssc_pkg::CRC_ONES;
                d.last   = last;
                pending_shards.insert(pending_shards.size(), d);
                crc_acc = ssc_pkg::CRC_ONES;
                taken   = '0;
                index   = last ? '0 : index + 1;
            end
            else
            begin
                taken = cnt[ssc_pkg::LEN_W-1:0];
            end
        endtask

        task check_shard(logic [ssc_pkg::NUM_W-1:0] number, logic [ssc_pkg::LEN_W-1:0] length,
                         logic [ssc_pkg::CRC_W-1:0] crc, logic last);
            shard_desc_t d;
            if (pending_shards.size() == 0)
            begin
                report($sformatf("unexpected shard num=%0d len=%0d crc=%h last=%b",
                                 number, length, crc, last));
                return;
            end
            d = pending_shards.pop_front();
            shards_checked++;
            if (number !== d.number)
                report($sformatf("shard_number got %0d want %0d", number, d.number));
            if (length !== d.length)
                report($sformatf("shard_length got %0d want %0d", length, d.length));
            if (crc !== d.crc)
                report($sformatf("crc_value got %h want %h", crc, d.crc));
            if (last !== d.last)
                report($sformatf("final_shard got %b want %b", last, d.last));
        endtask
    endclass

    shard_scoreboard sb;

    int sender_mode;
    int burst_left;
    int recv_mode;
    int recv_run;
    int settings_used;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb = new();
        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_data               = '0;
        stream_if.valid        = 1'b0;
        stream_if.data_byte    = '0;
        stream_if.object_end   = 1'b0;
        shard_if.ready         = 1'b0;
        sender_mode            = 0;
        burst_left             = 0;
        recv_mode              = 0;
        recv_run               = 0;
        settings_used          = 0;
    end

    // Receiver: always ready, random drops, or long runs of one level.
    always @(posedge clk)
    begin
        if (!rst_n)
            shard_if.ready <= 1'b0;
        else
        begin
            case (recv_mode)
                0: shard_if.ready <= 1'b1;
                1: shard_if.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (recv_run == 0)
                    begin
                        recv_run = $urandom_range(1, 12);
                        shard_if.ready <= ($urandom_range(0, 1) != 0);
                    end
                    else
                        recv_run--;
                end
            endcase
        end
    end

    // Transfer monitors.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stream_if.valid && stream_if.ready)
                sb.note_byte(stream_if.data_byte, stream_if.object_end);
            if (shard_if.valid && shard_if.ready)
                sb.check_shard(shard_if.shard_number, shard_if.shard_length,
                               shard_if.crc_value, shard_if.final_shard);
        end
    end

    // Called at a rising edge; returns at the edge where the byte was taken.
    task automatic send_byte(input logic [ssc_pkg::DATA_W-1:0] b, input logic last);
        int gap;
        if (sender_mode != 0)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 6);
                stream_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        stream_if.valid      <= 1'b1;
        stream_if.data_byte  <= b;
        stream_if.object_end <= last;
        do
            @(posedge clk);
        while (stream_if.ready !== 1'b1);
    endtask

    task automatic stop_stream();
        stream_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending_shards.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [ssc_pkg::LEN_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_size(v);
        settings_used++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_object(input int len, input bit cut_short);
        logic [ssc_pkg::DATA_W-1:0] b;
        int                         rnd;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: b = 8'h00;
                1: b = 8'hFF;
                default:
                begin
                    rnd = $urandom_range(0, 255);
                    b   = rnd[ssc_pkg::DATA_W-1:0];
                end
            endcase
            send_byte(b, (i == len - 1) && !cut_short);
        end
    endtask

    initial
    begin
        logic [ssc_pkg::LEN_W-1:0] sizes[NUM_PHASES];
        int phase_items;
        int len;
        int sent;
        int rnd;
        bit cut;

        sizes = '{25'd1, 25'd2, 25'd3, 25'd0, 25'd7, 25'd16, 25'd33, 25'h1FFFFFF,
                  25'd64, 25'd16777216, 25'd65536, 25'd5, 25'd16777217, 25'd0};
        rnd = $urandom_range(1, 48);
        sizes[11] = rnd[ssc_pkg::LEN_W-1:0];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size, single-byte objects at both byte extremes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        stop_stream();
        drain();

        // One-byte shards, object ends on a full shard.
        write_size(25'd1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        stop_stream();
        drain();

        // Shrink the size below what the open shard already holds.
        write_size(25'd8);
        send_byte(8'h31, 1'b0);
        send_byte(8'h32, 1'b0);
        send_byte(8'h33, 1'b0);
        stop_stream();
        drain();
        write_size(25'd2);
        send_byte(8'h34, 1'b0);
        send_byte(8'h35, 1'b1);
        stop_stream();
        drain();

        // Saturating size, zero size and the exact upper limit.
        write_size(25'h1FFFFFF);
        send_object(4, 1'b0);
        stop_stream();
        drain();
        write_size(25'd0);
        send_object(2, 1'b0);
        stop_stream();
        drain();
        write_size(ssc_pkg::SIZE_MAX);
        send_byte(8'h80, 1'b1);
        stop_stream();
        drain();

        // Random phases; some end with a shard left open across the size change.
        sent = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_size(sizes[ph]);
            sender_mode = (ph % 3 == 0) ? 0 : 1;
            recv_mode   = (ph + ph / 3) % 3;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(1, 48);
                if (len > PHASE_ITEMS - phase_items)
                    len = PHASE_ITEMS - phase_items;
                cut = (phase_items + len >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0);
                send_object(len, cut);
                phase_items += len;
            end
            sent += phase_items;
            stop_stream();
            drain();
        end

        recv_mode = 0;
        drain();

        $display("Run covered %0d bytes (%0d in random phases) over %0d size settings, %0d shards checked.",
                 sb.bytes_seen, sent, settings_used, sb.shards_checked);
        $display("Mismatches: %0d, shards still owed: %0d",
                 sb.errors, sb.pending_shards.size());
        if (sb.errors == 0 && sb.pending_shards.size() == 0)
            $display("shard_splitter_crc32 regression: pass");
        else
            $display("shard_splitter_crc32 regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting on the shard splitter");
        $display("shard_splitter_crc32 regression: fail");
        $finish;
    end

endmodule
